// ----- rtl/core/escs_pkg.sv -----
// Package: shared constants of the step crossfade sequencer.
package escs_pkg;
    localparam int MAX_STEPS_DEF = 16;
    localparam int FRAME_BITS_DEF = 16;
    localparam int FRAME_IN_BITS = 24;
    localparam int PHASE_BITS = 9;
    localparam int FRAC_BITS = 17;
    localparam int LEVEL_BITS = 8;
    localparam int CNT_BITS = 5;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;
    localparam logic [0:0] REG_STEP_COUNT = 1'b0;
endpackage

// ----- rtl/core/escs_front.sv -----
// Front end: step table loads and evaluate queue.
module escs_front #(
    parameter int MAX_STEPS = escs_pkg::MAX_STEPS_DEF,
    parameter int FRAME_BITS = escs_pkg::FRAME_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_func,
    input  logic [3:0] s_step_index,
    input  logic [15:0] s_fade_frames_in,
    input  logic [15:0] s_hold_frames_in,
    input  logic [7:0] s_level_in,
    input  logic s_level_present,
    input  logic [23:0] s_frame_number,
    input  logic [8:0] s_phase_degrees,
    output logic q_valid,
    input  logic q_ready,
    output logic [23:0] q_frame,
    output logic [8:0] q_phase,
    output logic [MAX_STEPS-1:0][FRAME_BITS-1:0] fade_tab,
    output logic [MAX_STEPS-1:0][FRAME_BITS-1:0] hold_tab,
    output logic [MAX_STEPS-1:0][7:0] lvl_tab
);
    logic [MAX_STEPS-1:0][FRAME_BITS-1:0] fade_reg, hold_reg;
    logic [MAX_STEPS-1:0][7:0] lvl_reg;
    logic [1:0] cnt_reg;
    logic [1:0][23:0] fq_reg;
    logic [1:0][8:0] pq_reg;
    logic wp_reg, rp_reg;
    logic push, pop;
    localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // a load waits until no evaluate is queued or running
    assign s_ready = (s_func == escs_pkg::FUNC_LOAD) ? (cnt_reg == 2'd0 && q_ready)
        : (cnt_reg != 2'd2);
    assign push = s_valid && s_ready && (s_func == escs_pkg::FUNC_EVAL);
    assign pop = q_valid && q_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_frame = fq_reg[rp_reg];
    assign q_phase = pq_reg[rp_reg];
    assign fade_tab = fade_reg;
    assign hold_tab = hold_reg;
    assign lvl_tab = lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            fade_reg <= '0;
            hold_reg <= '0;
            lvl_reg <= '0;
        end else begin
            if (push) begin
                fq_reg[wp_reg] <= s_frame_number;
                pq_reg[wp_reg] <= s_phase_degrees;
                wp_reg <= ~wp_reg;
            end
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (s_valid && s_ready && s_func == escs_pkg::FUNC_LOAD
                && 32'(s_step_index) < MAX_STEPS) begin
                fade_reg[IW'(s_step_index)] <= FRAME_BITS'(s_fade_frames_in);
                hold_reg[IW'(s_step_index)] <= FRAME_BITS'(s_hold_frames_in);
                lvl_reg[IW'(s_step_index)] <= s_level_present ? s_level_in : 8'd0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("queue lost entry");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
endmodule

// ----- rtl/core/escs_back.sv -----
// Back end: sequencer for total, phase offset, modulo, step walk, fade and level.
module escs_back #(
    parameter int MAX_STEPS = escs_pkg::MAX_STEPS_DEF,
    parameter int FRAME_BITS = escs_pkg::FRAME_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic [4:0] step_count,
    input  logic q_valid,
    output logic q_ready,
    input  logic [23:0] q_frame,
    input  logic [8:0] q_phase,
    input  logic [MAX_STEPS-1:0][FRAME_BITS-1:0] fade_tab,
    input  logic [MAX_STEPS-1:0][FRAME_BITS-1:0] hold_tab,
    input  logic [MAX_STEPS-1:0][7:0] lvl_tab,
    output logic m_valid,
    input  logic m_ready,
    output logic [4:0] m_step_number,
    output logic [16:0] m_fade_fraction,
    output logic [7:0] m_level_out
);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int TW = FRAME_BITS + 1 + SW;
    localparam int PW = TW + 9;
    localparam int AW = PW + 1;
    localparam int NW = FRAME_BITS + 17;
    // floor(x/360) = (x * RECIP360) >> RK, exact for x below 2^PW
    localparam int RK = PW + 9;
    localparam logic [PW:0] RECIP360 = (PW+1)'(((64'd1 << RK) + 64'd359) / 64'd360);
    localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_MUL = 4'd2,
        S_DIV = 4'd3, S_MOD = 4'd4, S_WALK = 4'd5, S_FDIV = 4'd6,
        S_LVL = 4'd7, S_OUT = 4'd8;

    logic [3:0] st_reg;
    logic [SW-1:0] cnt_reg, idx_reg;
    logic [TW-1:0] tot_reg;
    logic [AW-1:0] rem_reg;
    logic [PW-1:0] quo_reg;
    logic [23:0] frame_reg;
    logic [8:0] phase_reg;
    logic [6:0] bit_reg;
    logic [NW-1:0] num_reg;
    logic [16:0] frac_reg;
    logic [AW-1:0] acc_reg;
    logic [4:0] ostep_reg;
    logic [16:0] ofrac_reg;
    logic [7:0] olvl_reg;
    logic ov_reg;
    logic [SW-1:0] idx_m1, cnt_m1;
    logic [IW-1:0] ix_cur;
    logic [FRAME_BITS:0] len_cur;
    logic [2*PW:0] rprod;
    logic [NW:0] nsh;
    logic [7:0] prev, cur;
    logic [25:0] lacc;
    logic out_load;

    assign idx_m1 = idx_reg - SW'(1);
    assign cnt_m1 = cnt_reg - SW'(1);
    assign ix_cur = (idx_reg < SW'(MAX_STEPS)) ? idx_reg[IW-1:0] : '0;
    assign len_cur = {1'b0, fade_tab[ix_cur]} + {1'b0, hold_tab[ix_cur]};
    assign rprod = (2*PW+1)'(quo_reg) * (2*PW+1)'(RECIP360);
    assign nsh = {1'b0, num_reg} << 1;
    assign prev = (idx_reg != '0) ? lvl_tab[idx_m1[IW-1:0]]
        : ((cnt_reg != '0) ? lvl_tab[cnt_m1[IW-1:0]] : 8'd0);
    assign cur = lvl_tab[ix_cur];
    assign lacc = {2'b0, prev, 16'd0} + 26'(cur) * 26'(frac_reg)
        - 26'(prev) * 26'(frac_reg);
    assign out_load = (st_reg == S_OUT) && (!ov_reg || m_ready);

    assign q_ready = st_reg == S_IDLE;
    assign m_valid = ov_reg;
    assign m_step_number = ostep_reg;
    assign m_fade_fraction = ofrac_reg;
    assign m_level_out = olvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end else begin
            if (out_load) ov_reg <= 1'b1;
            else if (ov_reg && m_ready) ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (q_valid) begin
                    frame_reg <= q_frame;
                    phase_reg <= q_phase;
                    cnt_reg <= (32'(step_count) > MAX_STEPS) ? SW'(MAX_STEPS)
                        : SW'(step_count);
                    idx_reg <= '0;
                    tot_reg <= '0;
                    st_reg <= S_SUM;
                end
                S_SUM: begin
                    if (idx_reg == cnt_reg) begin
                        idx_reg <= '0;
                        frac_reg <= '0;
                        if (tot_reg == '0) st_reg <= S_LVL;
                        else begin
                            quo_reg <= PW'(phase_reg) * PW'(tot_reg);
                            st_reg <= S_MUL;
                        end
                    end else begin
                        tot_reg <= tot_reg + TW'(len_cur);
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_MUL: begin
                    quo_reg <= PW'(rprod[2*PW:RK]);
                    st_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= AW'(frame_reg) + AW'(quo_reg);
                    bit_reg <= 7'd0;
                    st_reg <= S_MOD;
                end
                S_MOD: begin
                    if (bit_reg == 7'd0) begin
                        acc_reg <= rem_reg;
                        rem_reg <= '0;
                        bit_reg <= 7'(AW);
                        num_reg <= '0;
                    end else if (bit_reg == 7'(AW + 1)) begin
                        frame_reg <= 24'(rem_reg);
                        st_reg <= S_WALK;
                    end
                    if (bit_reg != 7'd0 && bit_reg != 7'(AW + 1)) begin
                        logic [AW:0] r2;
                        r2 = {rem_reg, acc_reg[AW-1]};
                        acc_reg <= acc_reg << 1;
                        if (r2 >= (AW+1)'(tot_reg)) rem_reg <= AW'(r2 - (AW+1)'(tot_reg));
                        else rem_reg <= AW'(r2);
                        bit_reg <= (bit_reg == 7'd1) ? 7'(AW + 1) : bit_reg - 7'd1;
                    end
                end
                S_WALK: begin
                    if (idx_reg + SW'(1) < cnt_reg && 25'(frame_reg) >= 25'(len_cur)) begin
                        frame_reg <= frame_reg - 24'(len_cur);
                        idx_reg <= idx_reg + SW'(1);
                    end else if (frame_reg < 24'(fade_tab[ix_cur])) begin
                        num_reg <= NW'(frame_reg) << 16;
                        rem_reg <= '0;
                        frac_reg <= '0;
                        bit_reg <= 7'(NW);
                        st_reg <= S_FDIV;
                    end else begin
                        frac_reg <= 17'h10000;
                        st_reg <= S_LVL;
                    end
                end
                S_FDIV: begin
                    if (bit_reg == 7'd0) st_reg <= S_LVL;
                    else begin
                        logic [AW:0] r3;
                        r3 = {rem_reg, num_reg[NW-1]};
                        num_reg <= nsh[NW-1:0];
                        bit_reg <= bit_reg - 7'd1;
                        if (r3 >= (AW+1)'(fade_tab[ix_cur])) begin
                            rem_reg <= AW'(r3 - (AW+1)'(fade_tab[ix_cur]));
                            frac_reg <= {frac_reg[15:0], 1'b1};
                        end else begin
                            rem_reg <= AW'(r3);
                            frac_reg <= {frac_reg[15:0], 1'b0};
                        end
                    end
                end
                S_LVL: st_reg <= S_OUT;
                S_OUT: if (out_load) begin
                    olvl_reg <= lacc[23:16];
                    ostep_reg <= 5'(idx_reg) + 5'd1;
                    ofrac_reg <= frac_reg;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_ready) |=> ov_reg)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_WALK) |-> idx_reg < cnt_reg)
        else $error("walk beyond count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_OUT) |-> frac_reg <= 17'h10000)
        else $error("fraction out of range");
endmodule

// ----- rtl/core/effect_step_crossfade_sequencer.sv -----
// Top level of the lighting chase step crossfade sequencer.
// Input channel s_*: func 0 loads step step_index (fade, hold, level), func 1
// evaluates frame_number at phase_degrees. Loads give no result; a load waits
// until the queue is empty and the back end is idle.
// Evaluates go through a two-entry queue to the back end, which sums the step
// lengths (one step a cycle), divides phase*total by 360 with a reciprocal
// multiply, reduces the frame modulo the total bit-serially, walks the steps
// (one a cycle), and divides the fade fraction bit-serially. Results leave on
// m_* (step_number, fade_fraction Q1.16, level_out) from an output register; a
// stalled receiver holds the back end once it finishes, while the queue keeps
// taking evaluate words until it is full. Reset clears the step table, sets
// step_count to 1 and empties the queue. step_count is written over APB at
// address 0; the user must write it only while idle, as the block itself does
// not enforce this.
module effect_step_crossfade_sequencer #(
    parameter int MAX_STEPS = escs_pkg::MAX_STEPS_DEF,
    parameter int FRAME_BITS = escs_pkg::FRAME_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_func,
    input  logic [3:0] s_step_index,
    input  logic [15:0] s_fade_frames_in,
    input  logic [15:0] s_hold_frames_in,
    input  logic [7:0] s_level_in,
    input  logic s_level_present,
    input  logic [23:0] s_frame_number,
    input  logic [8:0] s_phase_degrees,
    output logic m_valid,
    input  logic m_ready,
    output logic [4:0] m_step_number,
    output logic [16:0] m_fade_fraction,
    output logic [7:0] m_level_out
);
    logic [4:0] step_count_reg;
    logic q_valid, q_ready;
    logic [23:0] q_frame;
    logic [8:0] q_phase;
    logic [MAX_STEPS-1:0][FRAME_BITS-1:0] fade_tab, hold_tab;
    logic [MAX_STEPS-1:0][7:0] lvl_tab;

    assign pready = 1'b1;
    assign prdata = (paddr == {1'b0, escs_pkg::REG_STEP_COUNT}) ? {27'd0, step_count_reg}
        : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) step_count_reg <= 5'd1;
        else if (psel && penable && pwrite && paddr == {1'b0, escs_pkg::REG_STEP_COUNT})
            step_count_reg <= pwdata[4:0];
    end

    escs_front #(.MAX_STEPS(MAX_STEPS), .FRAME_BITS(FRAME_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func, .s_step_index,
        .s_fade_frames_in, .s_hold_frames_in, .s_level_in, .s_level_present,
        .s_frame_number, .s_phase_degrees, .q_valid, .q_ready, .q_frame,
        .q_phase, .fade_tab, .hold_tab, .lvl_tab);

    escs_back #(.MAX_STEPS(MAX_STEPS), .FRAME_BITS(FRAME_BITS)) u_back (
        .aclk, .aresetn, .step_count(step_count_reg), .q_valid, .q_ready,
        .q_frame, .q_phase, .fade_tab, .hold_tab, .lvl_tab, .m_valid, .m_ready,
        .m_step_number, .m_fade_fraction, .m_level_out);
endmodule

// ----- bench/escs_checker.sv -----
// Checker: tracks the step table and step count, predicts each evaluate result and compares.
`timescale 1ns / 100ps
module escs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [3:0]  s_step_index,
    input  logic [15:0] s_fade_frames_in,
    input  logic [15:0] s_hold_frames_in,
    input  logic [7:0]  s_level_in,
    input  logic        s_level_present,
    input  logic [23:0] s_frame_number,
    input  logic [8:0]  s_phase_degrees,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [4:0]  m_step_number,
    input  logic [16:0] m_fade_fraction,
    input  logic [7:0]  m_level_out,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [4:0]  step;
        logic [16:0] frac;
        logic [7:0]  level;
    } chase_out_t;

    logic [4:0]  cnt_reg;
    logic [15:0] fade_tab [16];
    logic [15:0] hold_tab [16];
    logic [7:0]  lvl_tab [16];
    logic        lvl_ok [16];
    chase_out_t  chase_q [$];

    function automatic logic [7:0] level_at(int idx);
        if (idx < 0 || idx >= 16 || !lvl_ok[idx])
            return 8'd0;
        return lvl_tab[idx];
    endfunction

    function automatic chase_out_t chase_eval(logic [23:0] frame_in, logic [8:0] phase_in);
        chase_out_t r;
        int count;
        int step;
        longint unsigned total;
        longint unsigned frame;
        longint unsigned frac;
        longint unsigned prev;
        longint unsigned cur;
        longint unsigned acc;
        count = (cnt_reg > 16) ? 16 : cnt_reg;
        total = 0;
        for (int i = 0; i < count; i++)
            total += fade_tab[i] + hold_tab[i];
        step = 1;
        frac = 0;
        if (total > 0) begin
            frame = (frame_in + (phase_in * total) / 360) % total;
            while (step < count && frame >= fade_tab[step-1] + hold_tab[step-1]) begin
                frame -= fade_tab[step-1] + hold_tab[step-1];
                step++;
            end
            frac = 65536;
            if (frame < fade_tab[step-1])
                frac = (frame << 16) / fade_tab[step-1];
        end
        if (step > 1)
            prev = level_at(step - 2);
        else
            prev = (count >= 1) ? level_at(count - 1) : 0;
        cur = level_at(step - 1);
        if (cur >= prev)
            acc = (prev << 16) + (cur - prev) * frac;
        else
            acc = (prev << 16) - (prev - cur) * frac;
        r.step = step[4:0];
        r.frac = frac[16:0];
        r.level = acc[23:16];
        return r;
    endfunction

    assign pending = chase_q.size();

    always @(posedge aclk) begin
        chase_out_t want;
        if (!aresetn) begin
            cnt_reg <= 5'd1;
            for (int i = 0; i < 16; i++) begin
                fade_tab[i] = '0;
                hold_tab[i] = '0;
                lvl_tab[i] = '0;
                lvl_ok[i] = 1'b0;
            end
            chase_q.delete();
            errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == {1'b0, escs_pkg::REG_STEP_COUNT})
                cnt_reg <= pwdata[4:0];
            if (s_valid && s_ready) begin
                if (s_func == escs_pkg::FUNC_LOAD) begin
                    fade_tab[s_step_index] = s_fade_frames_in;
                    hold_tab[s_step_index] = s_hold_frames_in;
                    lvl_tab[s_step_index] = s_level_in;
                    lvl_ok[s_step_index] = s_level_present;
                end else begin
                    chase_q.push_back(chase_eval(s_frame_number, s_phase_degrees));
                end
            end
            if (m_valid && m_ready) begin
                if (chase_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected word: step %0d frac %0d level %0d",
                                 m_step_number, m_fade_fraction, m_level_out);
                    errors <= errors + 1;
                end else begin
                    want = chase_q.pop_front();
                    if (want.step !== m_step_number || want.frac !== m_fade_fraction ||
                        want.level !== m_level_out) begin
                        if (errors < 10)
                            $display("mismatch: exp step %0d frac %0d level %0d, got %0d %0d %0d",
                                     want.step, want.frac, want.level,
                                     m_step_number, m_fade_fraction, m_level_out);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- bench/effect_step_crossfade_sequencer_tb.sv -----
// Testbench top: clock, reset, APB writes, load/evaluate stimulus and verdict.
`timescale 1ns / 100ps
module effect_step_crossfade_sequencer_tb;
    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [3:0]  s_step_index;
    logic [15:0] s_fade_frames_in;
    logic [15:0] s_hold_frames_in;
    logic [7:0]  s_level_in;
    logic        s_level_present;
    logic [23:0] s_frame_number;
    logic [8:0]  s_phase_degrees;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_step_number;
    logic [16:0] m_fade_fraction;
    logic [7:0]  m_level_out;
    int          errors;
    int          pending;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          words_sent;

    effect_step_crossfade_sequencer dut (.*);

    escs_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_word(logic func, logic [3:0] idx, logic [15:0] fade,
                             logic [15:0] hold, logic [7:0] lvl, logic lvl_on,
                             logic [23:0] frame, logic [8:0] phase);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_step_index <= idx;
        s_fade_frames_in <= fade;
        s_hold_frames_in <= hold;
        s_level_in <= lvl;
        s_level_present <= lvl_on;
        s_frame_number <= frame;
        s_phase_degrees <= phase;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic load_step(logic [3:0] idx, logic [15:0] fade, logic [15:0] hold,
                             logic [7:0] lvl, logic lvl_on);
        send_word(escs_pkg::FUNC_LOAD, idx, fade, hold, lvl, lvl_on, 24'($urandom),
                  9'($urandom));
    endtask

    task automatic eval_frame(logic [23:0] frame, logic [8:0] phase);
        send_word(escs_pkg::FUNC_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 1'($urandom), frame, phase);
    endtask

    // drain results, let the back end settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_count(logic [4:0] cnt);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {1'b0, escs_pkg::REG_STEP_COUNT};
        pwdata <= {27'($urandom), cnt};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] rand_len();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'd0;
            default: return 16'($urandom_range(40));
        endcase
    endfunction

    function automatic logic [8:0] rand_phase();
        if ($urandom_range(9) == 0)
            return 9'($urandom);
        return 9'($urandom_range(359));
    endfunction

    initial begin
        logic [4:0] cnt;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_func = escs_pkg::FUNC_LOAD;
        s_step_index = '0;
        s_fade_frames_in = '0;
        s_hold_frames_in = '0;
        s_level_in = '0;
        s_level_present = 1'b0;
        s_frame_number = '0;
        s_phase_degrees = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        words_sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table: zero total
        eval_frame(24'hFFFFFF, 9'd359);
        write_count(5'd0);
        eval_frame(24'd5, 9'd0);
        wait_idle();
        load_step(4'd0, 16'd10, 16'd5, 8'd255, 1'b1);
        load_step(4'd1, 16'd0, 16'd7, 8'd0, 1'b1);
        load_step(4'd2, 16'hFFFF, 16'hFFFF, 8'hA5, 1'b0);
        load_step(4'd15, 16'd3, 16'd0, 8'd128, 1'b1);
        eval_frame(24'd0, 9'd0);
        write_count(5'd3);
        eval_frame(24'd4, 9'd0);
        eval_frame(24'd12, 9'd0);
        eval_frame(24'd15, 9'd0);
        eval_frame(24'd20, 9'd0);
        eval_frame(24'hFFFFFF, 9'd359);
        eval_frame(24'd0, 9'd511);
        eval_frame(24'd100, 9'd360);
        write_count(5'd16);
        eval_frame(24'd131086, 9'd0);
        eval_frame(24'd0, 9'd180);
        write_count(5'd31);
        eval_frame(24'd131086, 9'd0);
        eval_frame(24'h123456, 9'd90);
        write_count(5'd1);
        eval_frame(24'd3, 9'd0);
        eval_frame(24'd12, 9'd0);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = (ph == 1) ? 67 : (ph == 3) ? 15 : 0;
            rx_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 15 : 0;
            while (words_sent < 25 + (ph + 1) * 375) begin
                wait_idle();
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(5))
                        0: cnt = 5'd0;
                        1: cnt = 5'd16;
                        2: cnt = 5'($urandom);
                        default: cnt = 5'($urandom_range(1, 6));
                    endcase
                    write_count(cnt);
                end
                repeat ($urandom_range(1, 4))
                    load_step($urandom_range(2) == 0 ? 4'($urandom) : 4'($urandom_range(5)),
                              rand_len(), rand_len(), 8'($urandom), 1'($urandom));
                repeat ($urandom_range(4, 16)) begin
                    if ($urandom_range(1))
                        eval_frame(24'($urandom), rand_phase());
                    else
                        eval_frame(24'($urandom_range(200)), rand_phase());
                end
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
